FILE: sv/grain_spawn_slot_scheduler_defines.svh
// Assertion macros shared by the grain spawn slot scheduler RTL
`ifndef GRAIN_SPAWN_SLOT_SCHEDULER_DEFINES_SVH
`define GRAIN_SPAWN_SLOT_SCHEDULER_DEFINES_SVH

// Condition and consequence in the same cycle
`define GSS_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Consequence in the cycle after the condition
`define GSS_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/gss_pkg.sv
// Shared types and constants of the grain spawn slot scheduler
`default_nettype none

package gss_pkg;

    // Field and register widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 36;
    localparam int CHANS_W    = 7;
    localparam int MODE_W     = 2;
    localparam int SLOTS_W    = 6;
    localparam int LEN_W      = 18;
    localparam int INTERVAL_W = 36;
    localparam int TIMER_W    = 38;
    localparam int SLOT_OUT_W = 5;
    localparam int CHAN_OUT_W = 6;
    localparam int COUNT_W    = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

    // Routing modes (the unused code behaves as round robin)
    localparam logic [MODE_W-1:0] ROUTE_RR = 2'd0;
    localparam logic [MODE_W-1:0] ROUTE_PP = 2'd1;
    localparam logic [MODE_W-1:0] ROUTE_CO = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROUTE_MODE     = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOT_COUNT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_GRAIN_LENGTH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPAWN_INTERVAL = 3'd4;

    // Register reset values
    localparam logic [CHANS_W-1:0]    RST_CHANNEL_COUNT  = 7'd2;
    localparam logic [MODE_W-1:0]     RST_ROUTE_MODE     = 2'd0;
    localparam logic [SLOTS_W-1:0]    RST_SLOT_COUNT     = 6'd8;
    localparam logic [LEN_W-1:0]      RST_GRAIN_LENGTH   = 18'd4800;
    localparam logic [INTERVAL_W-1:0] RST_SPAWN_INTERVAL = 36'd78643200;

    // Fixed-point one sample, and lower limits
    localparam logic [TIMER_W-1:0]    FRAC_ONE     = 38'd65536;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL = 36'd65536;
    localparam logic [LEN_W-1:0]      MIN_LENGTH   = 18'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_all;
        logic timer_zero;
        logic timer_dec;
        logic scan_start;
        logic scan_search;
        logic rem_start;
        logic commit;
        logic out_load;
    } gss_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic spawn;
        logic scan_done;
        logic rem_done;
        logic out_free;
    } gss_sts_t;

endpackage

`default_nettype wire

FILE: sv/gss_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none

module gss_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/gss_ctrl.sv
// Sequencing state machine of the grain spawn slot scheduler
`default_nettype none

module gss_ctrl
    import gss_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [OP_W-1:0] op,
    input  wire logic            notes_held,
    input  wire gss_sts_t        sts,
    output gss_cmd_t             cmd,
    output logic                 idle
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TICK   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_ROUTE  = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_AGE    = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (op)
                        OP_RESET:   cmd.clear_all  = 1'b1;
                        OP_NOTE_ON: cmd.timer_zero = 1'b1;
                        OP_TICK:    cmd.timer_dec  = notes_held;
                        default:    cmd.load       = 1'b1;
                    endcase
                    if (op == OP_TICK && notes_held)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_AGE;
                    end
                end
            end
            S_TICK:
            begin
                cmd.scan_start = 1'b1;
                if (sts.spawn)
                begin
                    cmd.scan_search = 1'b1;
                    cmd.rem_start   = 1'b1;
                    state_next      = S_SEARCH;
                end
                else
                begin
                    state_next = S_AGE;
                end
            end
            S_SEARCH:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                if (sts.rem_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_AGE;
            end
            S_AGE:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

`default_nettype wire

FILE: sv/gss_datapath.sv
// Slot store, spawn timer, routing and result registers of the scheduler
`default_nettype none

`include "grain_spawn_slot_scheduler_defines.svh"

module gss_datapath
    import gss_pkg::*;
#(
    parameter int MAX_SLOTS    = 32,
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gss_cmd_t              cmd,
    output gss_sts_t                   sts,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic                       spawned,
    output logic [SLOT_OUT_W-1:0]      slot,
    output logic [CHAN_OUT_W-1:0]      channel,
    output logic                       stolen,
    output logic [COUNT_W-1:0]         active_count
);

    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SNW = $clog2(MAX_SLOTS + 1);
    localparam int CW  = $clog2(MAX_CHANNELS);
    localparam int NW  = $clog2(MAX_CHANNELS + 1);
    localparam int RCW = (CW > 1) ? $clog2(CW) : 1;
    localparam int DW  = 2 * LEN_W;

    // Configuration registers
    logic [CHANS_W-1:0]    cfg_channels_reg;
    logic [MODE_W-1:0]     cfg_mode_reg;
    logic [SLOTS_W-1:0]    cfg_slots_reg;
    logic [LEN_W-1:0]      cfg_length_reg;
    logic [INTERVAL_W-1:0] cfg_interval_reg;

    // Slot state
    logic [MAX_SLOTS-1:0]  active_reg;
    logic [MAX_SLOTS-1:0]  active_next;
    logic [MAX_SLOTS-1:0]  used_mask;
    logic [MAX_SLOTS-1:0]  new_mask;
    logic [SNW-1:0]        ns;
    logic [SNW-1:0]        new_ns;

    // Timer and routing state
    logic signed [TIMER_W-1:0] timer_reg;
    logic [CW-1:0]             rr_reg;
    logic [CW-1:0]             co_reg;
    logic [CW-1:0]             pp_pos_reg;
    logic                      pp_up_reg;

    // Scan pipeline
    logic [SNW-1:0] issue_idx_reg;
    logic [SNW-1:0] issue_inc;
    logic           issuing_reg;
    logic           p_valid_reg;
    logic [SW-1:0]  p_idx_reg;
    logic           scan_search_reg;
    logic           do_age_reg;
    logic           found_reg;
    logic [SW-1:0]  free_idx_reg;
    logic [SW-1:0]  best_idx_reg;
    logic [LEN_W-1:0] best_age_reg;
    logic [SNW-1:0] count_reg;

    // Slot RAM ports
    logic           ram_we;
    logic [SW-1:0]  ram_waddr;
    logic [DW-1:0]  ram_wdata;
    logic [DW-1:0]  ram_rdata;
    logic [LEN_W-1:0] rd_age;
    logic [LEN_W-1:0] rd_len;
    logic           rd_active;
    logic           rd_expire;
    logic           age_expire;
    logic           age_write;

    // Remainder unit
    logic [CW-1:0]  rem_div_reg;
    logic [NW-1:0]  rem_r_reg;
    logic [RCW-1:0] rem_cnt_reg;
    logic           rem_busy_reg;
    logic           rem_done_reg;
    logic [NW:0]    rem_trial;
    logic [NW:0]    nc_ext;

    // Routing decisions
    logic [NW-1:0]  nc;
    logic [NW-1:0]  k_inc;
    logic [NW-1:0]  k_wrap;
    logic [NW-1:0]  co_mid;
    logic [NW-1:0]  co_half;
    logic [NW-1:0]  co_sel;
    logic [NW-1:0]  pp_cur;
    logic [NW-1:0]  pp_new;
    logic           pp_up_new;
    logic [NW-1:0]  route_sel;

    // Result of the item in progress
    logic           res_spawned_reg;
    logic [SW-1:0]  res_slot_reg;
    logic [CW-1:0]  res_channel_reg;
    logic           res_stolen_reg;
    logic [SW-1:0]  slot_sel;
    logic [LEN_W-1:0]      len_eff;
    logic [INTERVAL_W-1:0] iv_eff;

    // Output register
    logic                  out_valid_reg;
    logic                  out_spawned_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [CHAN_OUT_W-1:0] out_channel_reg;
    logic                  out_stolen_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    function automatic logic [SNW-1:0] clamp_slots(input logic [SLOTS_W-1:0] v);
        logic [SNW-1:0] r;
        if (v == '0)
        begin
            r = SNW'(1);
        end
        else if (32'(v) > MAX_SLOTS)
        begin
            r = SNW'(MAX_SLOTS);
        end
        else
        begin
            r = SNW'(v);
        end
        return r;
    endfunction

    // Clamped counts and slot masks
    always_comb
    begin
        ns     = clamp_slots(cfg_slots_reg);
        new_ns = clamp_slots(cfg_data[SLOTS_W-1:0]);
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            used_mask[i] = (i < int'(ns));
            new_mask[i]  = (i < int'(new_ns));
        end
        if (cfg_channels_reg == '0)
        begin
            nc = NW'(1);
        end
        else if (32'(cfg_channels_reg) > MAX_CHANNELS)
        begin
            nc = NW'(MAX_CHANNELS);
        end
        else
        begin
            nc = NW'(cfg_channels_reg);
        end
        len_eff = (cfg_length_reg < MIN_LENGTH) ? MIN_LENGTH : cfg_length_reg;
        iv_eff  = (cfg_interval_reg < MIN_INTERVAL) ? MIN_INTERVAL : cfg_interval_reg;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_channels_reg <= RST_CHANNEL_COUNT;
            cfg_mode_reg     <= RST_ROUTE_MODE;
            cfg_slots_reg    <= RST_SLOT_COUNT;
            cfg_length_reg   <= RST_GRAIN_LENGTH;
            cfg_interval_reg <= RST_SPAWN_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT:  cfg_channels_reg <= cfg_data[CHANS_W-1:0];
                REG_ROUTE_MODE:     cfg_mode_reg     <= cfg_data[MODE_W-1:0];
                REG_SLOT_COUNT:     cfg_slots_reg    <= cfg_data[SLOTS_W-1:0];
                REG_GRAIN_LENGTH:   cfg_length_reg   <= cfg_data[LEN_W-1:0];
                REG_SPAWN_INTERVAL: cfg_interval_reg <= cfg_data[INTERVAL_W-1:0];
                default:            cfg_mode_reg     <= cfg_mode_reg;
            endcase
        end
    end

    // Slot RAM: age in the upper half, latched length in the lower half
    gss_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg[SW-1:0]),
        .rdata (ram_rdata)
    );

    // Processing stage of the scan
    assign rd_age     = ram_rdata[DW-1:LEN_W];
    assign rd_len     = ram_rdata[LEN_W-1:0];
    assign rd_active  = active_reg[p_idx_reg];
    assign rd_expire  = (rd_age >= rd_len);
    assign age_expire = p_valid_reg && !scan_search_reg && do_age_reg && rd_active && rd_expire;
    assign age_write  = p_valid_reg && !scan_search_reg && do_age_reg && rd_active && !rd_expire;
    assign slot_sel   = found_reg ? free_idx_reg : best_idx_reg;

    always_comb
    begin
        if (cmd.commit)
        begin
            ram_we    = 1'b1;
            ram_waddr = slot_sel;
            ram_wdata = {{LEN_W{1'b0}}, len_eff};
        end
        else
        begin
            ram_we    = age_write;
            ram_waddr = p_idx_reg;
            ram_wdata = {rd_age + LEN_W'(1), rd_len};
        end
    end

    // Active bits
    always_comb
    begin
        active_next = active_reg;
        if (cmd.clear_all)
        begin
            active_next = '0;
        end
        if (cfg_we && cfg_index == REG_SLOT_COUNT)
        begin
            active_next = active_reg & new_mask;
        end
        if (cmd.commit)
        begin
            active_next[slot_sel] = 1'b1;
        end
        if (age_expire)
        begin
            active_next[p_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Scan issue and processing, one slot per cycle
    assign issue_inc = issue_idx_reg + SNW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg   <= '0;
            issuing_reg     <= 1'b0;
            p_valid_reg     <= 1'b0;
            p_idx_reg       <= '0;
            scan_search_reg <= 1'b0;
            do_age_reg      <= 1'b0;
            found_reg       <= 1'b0;
            free_idx_reg    <= '0;
            best_idx_reg    <= '0;
            best_age_reg    <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                do_age_reg <= (op == OP_TICK);
            end
            if (cmd.scan_start)
            begin
                issue_idx_reg   <= '0;
                issuing_reg     <= 1'b1;
                p_valid_reg     <= 1'b0;
                scan_search_reg <= cmd.scan_search;
                if (cmd.scan_search)
                begin
                    found_reg    <= 1'b0;
                    best_idx_reg <= '0;
                    best_age_reg <= '0;
                end
                else
                begin
                    count_reg <= '0;
                end
            end
            else
            begin
                p_valid_reg <= issuing_reg;
                p_idx_reg   <= issue_idx_reg[SW-1:0];
                if (issuing_reg)
                begin
                    issue_idx_reg <= issue_inc;
                    if (issue_inc == ns)
                    begin
                        issuing_reg <= 1'b0;
                    end
                end
                if (p_valid_reg && scan_search_reg)
                begin
                    // lowest free slot, and oldest slot (first on ties)
                    if (!rd_active && !found_reg)
                    begin
                        found_reg    <= 1'b1;
                        free_idx_reg <= p_idx_reg;
                    end
                    if (rd_age > best_age_reg)
                    begin
                        best_age_reg <= rd_age;
                        best_idx_reg <= p_idx_reg;
                    end
                end
                if (p_valid_reg && !scan_search_reg && rd_active && !age_expire)
                begin
                    count_reg <= count_reg + SNW'(1);
                end
            end
        end
    end

    // Spawn timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
        end
        else if (cmd.clear_all || cmd.timer_zero)
        begin
            timer_reg <= '0;
        end
        else if (cmd.timer_dec)
        begin
            timer_reg <= timer_reg - $signed(FRAC_ONE);
        end
        else if (cmd.commit)
        begin
            timer_reg <= timer_reg + $signed({{(TIMER_W - INTERVAL_W){1'b0}}, iv_eff});
        end
    end

    // Restoring remainder of the routing position by the channel count
    assign nc_ext    = {1'b0, nc};
    assign rem_trial = {rem_r_reg, rem_div_reg[CW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_div_reg  <= '0;
            rem_r_reg    <= '0;
            rem_cnt_reg  <= '0;
            rem_busy_reg <= 1'b0;
            rem_done_reg <= 1'b0;
        end
        else if (cmd.rem_start)
        begin
            rem_div_reg  <= (cfg_mode_reg == ROUTE_CO) ? co_reg : rr_reg;
            rem_r_reg    <= '0;
            rem_cnt_reg  <= '0;
            rem_busy_reg <= 1'b1;
            rem_done_reg <= 1'b0;
        end
        else if (rem_busy_reg)
        begin
            rem_div_reg <= rem_div_reg << 1;
            if (rem_trial >= nc_ext)
            begin
                rem_r_reg <= NW'(rem_trial - nc_ext);
            end
            else
            begin
                rem_r_reg <= NW'(rem_trial);
            end
            rem_cnt_reg <= rem_cnt_reg + RCW'(1);
            if (rem_cnt_reg == RCW'(CW - 1))
            begin
                rem_busy_reg <= 1'b0;
                rem_done_reg <= 1'b1;
            end
        end
    end

    // Channel choice for the three routing orders
    always_comb
    begin
        k_inc   = rem_r_reg + NW'(1);
        k_wrap  = (k_inc == nc) ? '0 : k_inc;
        co_mid  = nc >> 1;
        co_half = rem_r_reg >> 1;
        if (nc[0])
        begin
            if (rem_r_reg == '0)
            begin
                co_sel = co_mid;
            end
            else if (rem_r_reg[0])
            begin
                co_sel = co_mid - co_half - NW'(1);
            end
            else
            begin
                co_sel = co_mid + co_half;
            end
        end
        else if (!rem_r_reg[0])
        begin
            co_sel = co_mid - NW'(1) - co_half;
        end
        else
        begin
            co_sel = co_mid + co_half;
        end

        // ping pong: clamp a stale position, then bounce at either end
        pp_cur    = (NW'(pp_pos_reg) >= nc) ? nc - NW'(1) : NW'(pp_pos_reg);
        pp_new    = pp_cur;
        pp_up_new = pp_up_reg;
        if (pp_up_reg)
        begin
            if (pp_cur + NW'(1) >= nc)
            begin
                pp_up_new = 1'b0;
                if (pp_cur != '0)
                begin
                    pp_new = pp_cur - NW'(1);
                end
            end
            else
            begin
                pp_new = pp_cur + NW'(1);
            end
        end
        else if (pp_cur == '0)
        begin
            pp_up_new = 1'b1;
            pp_new    = NW'(1);
        end
        else
        begin
            pp_new = pp_cur - NW'(1);
        end

        if (nc <= NW'(1))
        begin
            route_sel = '0;
        end
        else
        begin
            case (cfg_mode_reg)
                ROUTE_PP: route_sel = pp_cur;
                ROUTE_CO: route_sel = co_sel;
                default:  route_sel = rem_r_reg;
            endcase
        end
    end

    // Routing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_reg     <= '0;
            co_reg     <= '0;
            pp_pos_reg <= '0;
            pp_up_reg  <= 1'b1;
        end
        else if (cmd.clear_all)
        begin
            rr_reg     <= '0;
            co_reg     <= '0;
            pp_pos_reg <= '0;
            pp_up_reg  <= 1'b1;
        end
        else if (cmd.commit && nc > NW'(1))
        begin
            case (cfg_mode_reg)
                ROUTE_PP:
                begin
                    pp_pos_reg <= CW'(pp_new);
                    pp_up_reg  <= pp_up_new;
                end
                ROUTE_CO: co_reg <= CW'(k_wrap);
                default:  rr_reg <= CW'(k_wrap);
            endcase
        end
    end

    // Result of the current item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_spawned_reg <= 1'b0;
            res_slot_reg    <= '0;
            res_channel_reg <= '0;
            res_stolen_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            res_spawned_reg <= 1'b0;
            res_slot_reg    <= '0;
            res_channel_reg <= '0;
            res_stolen_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_spawned_reg <= 1'b1;
            res_slot_reg    <= slot_sel;
            res_channel_reg <= CW'(route_sel);
            res_stolen_reg  <= !found_reg;
        end
    end

    // Output register: holds a finished transfer while the next item runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_spawned_reg <= res_spawned_reg;
            out_slot_reg    <= SLOT_OUT_W'(res_slot_reg);
            out_channel_reg <= CHAN_OUT_W'(res_channel_reg);
            out_stolen_reg  <= res_stolen_reg;
            out_count_reg   <= COUNT_W'(count_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign spawned      = out_spawned_reg;
    assign slot         = out_slot_reg;
    assign channel      = out_channel_reg;
    assign stolen       = out_stolen_reg;
    assign active_count = out_count_reg;

    // Status to the controller
    assign sts.spawn     = timer_reg[TIMER_W-1] || (timer_reg == '0);
    assign sts.scan_done = !issuing_reg && !p_valid_reg;
    assign sts.rem_done  = rem_done_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    `GSS_ASSERT_NOW(a_no_active_above_limit, clk, rst_n, 1'b1, (active_reg & ~used_mask) == '0, "active slot at or above the slot count")
    `GSS_ASSERT_NOW(a_steal_only_when_full, clk, rst_n, cmd.commit && !found_reg, (active_reg & used_mask) == used_mask, "slot stolen while a free slot exists")
    `GSS_ASSERT_NEXT(a_timer_nonneg_after_spawn, clk, rst_n, cmd.commit, !timer_reg[TIMER_W-1], "spawn timer negative after a spawn")
    `GSS_ASSERT_NOW(a_scan_start_when_idle, clk, rst_n, cmd.scan_start, !issuing_reg && !p_valid_reg, "scan started while a scan is running")

endmodule

`default_nettype wire

FILE: sv/grain_spawn_slot_scheduler.sv
// One item is in work at a time. Its work is the slot RAM scan, one slot per cycle
// (search, then ageing), and the bit-serial remainder unit for the routing position.
// The search and the remainder unit run only for an item that spawns.
// A finished result waits in the output register while the next item is taken.
// Reset: registers to their defaults, all slots free, timer and routing cleared at once.
`default_nettype none

module grain_spawn_slot_scheduler
    import gss_pkg::*;
#(
    parameter int MAX_SLOTS    = 32,
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic                  notes_held,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       spawned,
    output logic [SLOT_OUT_W-1:0]      slot,
    output logic [CHAN_OUT_W-1:0]      channel,
    output logic                       stolen,
    output logic [COUNT_W-1:0]         active_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    gss_cmd_t cmd;
    gss_sts_t sts;
    logic     ctrl_idle;
    logic     cfg_we;

    // Items and register transfers are taken only between items
    assign in_stall  = !ctrl_idle;
    assign cfg_ready = ctrl_idle;
    assign cfg_we    = cfg_valid && cfg_ready;

    gss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .op         (op),
        .notes_held (notes_held),
        .sts        (sts),
        .cmd        (cmd),
        .idle       (ctrl_idle)
    );

    gss_datapath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .spawned      (spawned),
        .slot         (slot),
        .channel      (channel),
        .stolen       (stolen),
        .active_count (active_count)
    );

endmodule

`default_nettype wire
